[sv/lfu_cache_lru_tiebreak_unit_defines.svh]
// Assertion helpers shared by the checker.
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LFUC_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("lfuc check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define LFUC_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("lfuc check failed");

`endif

[sv/lfuc_pkg.sv]
package lfuc_pkg;

   localparam int unsigned CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word select within the register window (paddr[2])
   localparam logic CSR_WORD_CAPACITY = 1'b0;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   // status of the search record as it walks the cell row
   typedef struct packed {
      logic valid;
      logic found;
      logic victim_ok;
      logic free_ok;
   } probe_flags_type;

   // update broadcast to all cells at the end of a request
   typedef struct packed {
      logic en;
      logic drop_en;
      logic inc;
      logic install;
      logic write_value;
   } cmd_type;

endpackage

[sv/lfuc_csr.sv]
module lfuc_csr
   import lfuc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [CAP_W-1:0] capacity
);

   logic [CAP_W-1:0] cap_ff;
   logic             wr_en;

   assign wr_en = psel && penable && pwrite && (paddr[2] == CSR_WORD_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (wr_en) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_WORD_CAPACITY) begin
         prdata = {{(32 - CAP_W){1'b0}}, cap_ff};
      end
   end

   assign pready   = 1'b1;
   assign capacity = cap_ff;

endmodule

[sv/lfuc_cell.sv]
module lfuc_cell
   import lfuc_pkg::*;
#(
   parameter int unsigned CAPACITY    = 16,
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned INDEX       = 0,
   localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int unsigned RANK_W = IDX_W,
   localparam int unsigned OCC_W  = $clog2(CAPACITY + 1)
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            look_key,
   input  probe_flags_type        in_flags,
   input  logic [IDX_W-1:0]       in_found_idx,
   input  logic [RANK_W-1:0]      in_found_rank,
   input  logic [31:0]            in_found_value,
   input  logic [IDX_W-1:0]       in_victim_idx,
   input  logic [COUNT_WIDTH-1:0] in_victim_count,
   input  logic [RANK_W-1:0]      in_victim_rank,
   input  logic [31:0]            in_victim_key,
   input  logic [IDX_W-1:0]       in_free_idx,
   input  logic [OCC_W-1:0]       in_occ,
   output probe_flags_type        out_flags,
   output logic [IDX_W-1:0]       out_found_idx,
   output logic [RANK_W-1:0]      out_found_rank,
   output logic [31:0]            out_found_value,
   output logic [IDX_W-1:0]       out_victim_idx,
   output logic [COUNT_WIDTH-1:0] out_victim_count,
   output logic [RANK_W-1:0]      out_victim_rank,
   output logic [31:0]            out_victim_key,
   output logic [IDX_W-1:0]       out_free_idx,
   output logic [OCC_W-1:0]       out_occ,
   input  cmd_type                cmd,
   input  logic [IDX_W-1:0]       cmd_idx,
   input  logic [RANK_W-1:0]      cmd_drop_rank,
   input  logic [RANK_W-1:0]      cmd_new_rank,
   input  logic [31:0]            cmd_key,
   input  logic [31:0]            cmd_value
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   // stored entry
   logic                   valid_ff;
   logic [31:0]            key_ff;
   logic [31:0]            value_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [RANK_W-1:0]      rank_ff;

   // search record handed to the next cell
   probe_flags_type        flags_ff,        flags_in;
   logic [IDX_W-1:0]       found_idx_ff,    found_idx_in;
   logic [RANK_W-1:0]      found_rank_ff,   found_rank_in;
   logic [31:0]            found_value_ff,  found_value_in;
   logic [IDX_W-1:0]       victim_idx_ff,   victim_idx_in;
   logic [COUNT_WIDTH-1:0] victim_count_ff, victim_count_in;
   logic [RANK_W-1:0]      victim_rank_ff,  victim_rank_in;
   logic [31:0]            victim_key_ff,   victim_key_in;
   logic [IDX_W-1:0]       free_idx_ff,     free_idx_in;
   logic [OCC_W-1:0]       occ_ff,          occ_in;

   logic match, better, free_here, target, drop_here;

   assign match     = valid_ff && (key_ff == look_key) && !in_flags.found;
   // strict compare keeps the earlier cell on a full tie
   assign better    = valid_ff && (!in_flags.victim_ok || (count_ff < in_victim_count) ||
                      ((count_ff == in_victim_count) && (rank_ff < in_victim_rank)));
   assign free_here = !valid_ff && !in_flags.free_ok;

   always_comb begin
      flags_in        = in_flags;
      found_idx_in    = in_found_idx;
      found_rank_in   = in_found_rank;
      found_value_in  = in_found_value;
      victim_idx_in   = in_victim_idx;
      victim_count_in = in_victim_count;
      victim_rank_in  = in_victim_rank;
      victim_key_in   = in_victim_key;
      free_idx_in     = in_free_idx;
      occ_in          = in_occ + OCC_W'(valid_ff);
      if (match) begin
         flags_in.found = 1'b1;
         found_idx_in   = MY_IDX;
         found_rank_in  = rank_ff;
         found_value_in = value_ff;
      end
      if (better) begin
         flags_in.victim_ok = 1'b1;
         victim_idx_in      = MY_IDX;
         victim_count_in    = count_ff;
         victim_rank_in     = rank_ff;
         victim_key_in      = key_ff;
      end
      if (free_here) begin
         flags_in.free_ok = 1'b1;
         free_idx_in      = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff    <= found_idx_in;
      found_rank_ff   <= found_rank_in;
      found_value_ff  <= found_value_in;
      victim_idx_ff   <= victim_idx_in;
      victim_count_ff <= victim_count_in;
      victim_rank_ff  <= victim_rank_in;
      victim_key_ff   <= victim_key_in;
      free_idx_ff     <= free_idx_in;
      occ_ff          <= occ_in;
   end

   assign target    = cmd.en && (cmd_idx == MY_IDX);
   assign drop_here = cmd.en && cmd.drop_en && !target && valid_ff &&
                      (rank_ff > cmd_drop_rank);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (target && cmd.install) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (target) begin
         rank_ff <= cmd_new_rank;
         if (cmd.install) begin
            key_ff <= cmd_key;
         end
         if (cmd.write_value) begin
            value_ff <= cmd_value;
         end
         if (!cmd.inc) begin
            count_ff <= COUNT_WIDTH'(1);
         end else if (count_ff != '1) begin
            count_ff <= count_ff + COUNT_WIDTH'(1);
         end
      end else if (drop_here) begin
         rank_ff <= rank_ff - RANK_W'(1);
      end
   end

   assign out_flags        = flags_ff;
   assign out_found_idx    = found_idx_ff;
   assign out_found_rank   = found_rank_ff;
   assign out_found_value  = found_value_ff;
   assign out_victim_idx   = victim_idx_ff;
   assign out_victim_count = victim_count_ff;
   assign out_victim_rank  = victim_rank_ff;
   assign out_victim_key   = victim_key_ff;
   assign out_free_idx     = free_idx_ff;
   assign out_occ          = occ_ff;

endmodule

[sv/lfu_cache_lru_tiebreak_unit.sv]
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break.
// Request channel (req_valid/req_ready): func (0 get, 1 put), key, value.
// Response channel (rsp_valid/rsp_ready): hit, read_value, evicted,
// evicted_key; exactly one response per request, in order.
// Configuration: APB-style port, capacity_in_use at byte address 0.
// Entries sit in a row of CAPACITY cells; a search record walks the row one
// cell per cycle collecting the key match, the eviction candidate, the first
// free slot and the occupancy, then one update is broadcast to all cells.
// The response is formed once the cell row walk ends. One request is in
// flight at a time, so a new request is taken only after the last one has
// finished its walk and update.
// The response sits in an output register: a new request is accepted while
// it waits. If the receiver stalls, a finished request holds in its last
// step until the output register frees up.
// Reset clears all valid marks and sets capacity_in_use to 16.
module lfu_cache_lru_tiebreak_unit
   import lfuc_pkg::*;
#(
   parameter int unsigned CAPACITY    = 16,
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_value,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_key,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned RANK_W = IDX_W;
   localparam int unsigned OCC_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [CAP_W-1:0] capacity;

   lfuc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   ctrl_state_type state_ff, state_in;
   logic           accept, capture, finish_go, out_free;

   logic        start_ff;
   logic        func_ff;
   logic [31:0] key_ff;
   logic [31:0] value_ff;

   // cell row
   probe_flags_type        ch_flags        [CAPACITY+1];
   logic [IDX_W-1:0]       ch_found_idx    [CAPACITY+1];
   logic [RANK_W-1:0]      ch_found_rank   [CAPACITY+1];
   logic [31:0]            ch_found_value  [CAPACITY+1];
   logic [IDX_W-1:0]       ch_victim_idx   [CAPACITY+1];
   logic [COUNT_WIDTH-1:0] ch_victim_count [CAPACITY+1];
   logic [RANK_W-1:0]      ch_victim_rank  [CAPACITY+1];
   logic [31:0]            ch_victim_key   [CAPACITY+1];
   logic [IDX_W-1:0]       ch_free_idx     [CAPACITY+1];
   logic [OCC_W-1:0]       ch_occ          [CAPACITY+1];

   cmd_type           cmd_raw, cmd;
   logic [IDX_W-1:0]  cmd_idx;
   logic [RANK_W-1:0] cmd_drop_rank, cmd_new_rank;

   // search result captured at the end of the row
   probe_flags_type   hold_flags_ff;
   logic [IDX_W-1:0]  hold_found_idx_ff;
   logic [RANK_W-1:0] hold_found_rank_ff;
   logic [31:0]       hold_found_value_ff;
   logic [IDX_W-1:0]  hold_victim_idx_ff;
   logic [RANK_W-1:0] hold_victim_rank_ff;
   logic [31:0]       hold_victim_key_ff;
   logic [IDX_W-1:0]  hold_free_idx_ff;
   logic [OCC_W-1:0]  hold_occ_ff;

   logic        res_hit, res_evicted;
   logic [31:0] res_read_value, res_evicted_key;

   logic        rsp_valid_ff;
   logic        rsp_hit_ff, rsp_evicted_ff;
   logic [31:0] rsp_read_value_ff, rsp_evicted_key_ff;

   logic [CMP_W-1:0] cap_ext, cap_lim, occ_ext;
   logic [OCC_W-1:0] occ_dec;
   logic             full, no_room;

   assign ch_flags[0]        = '{valid: start_ff, found: 1'b0, victim_ok: 1'b0,
                                 free_ok: 1'b0};
   assign ch_found_idx[0]    = '0;
   assign ch_found_rank[0]   = '0;
   assign ch_found_value[0]  = '0;
   assign ch_victim_idx[0]   = '0;
   assign ch_victim_count[0] = '0;
   assign ch_victim_rank[0]  = '0;
   assign ch_victim_key[0]   = '0;
   assign ch_free_idx[0]     = '0;
   assign ch_occ[0]          = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lfuc_cell #(
         .CAPACITY    (CAPACITY),
         .COUNT_WIDTH (COUNT_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .look_key         (key_ff),
         .in_flags         (ch_flags[i]),
         .in_found_idx     (ch_found_idx[i]),
         .in_found_rank    (ch_found_rank[i]),
         .in_found_value   (ch_found_value[i]),
         .in_victim_idx    (ch_victim_idx[i]),
         .in_victim_count  (ch_victim_count[i]),
         .in_victim_rank   (ch_victim_rank[i]),
         .in_victim_key    (ch_victim_key[i]),
         .in_free_idx      (ch_free_idx[i]),
         .in_occ           (ch_occ[i]),
         .out_flags        (ch_flags[i+1]),
         .out_found_idx    (ch_found_idx[i+1]),
         .out_found_rank   (ch_found_rank[i+1]),
         .out_found_value  (ch_found_value[i+1]),
         .out_victim_idx   (ch_victim_idx[i+1]),
         .out_victim_count (ch_victim_count[i+1]),
         .out_victim_rank  (ch_victim_rank[i+1]),
         .out_victim_key   (ch_victim_key[i+1]),
         .out_free_idx     (ch_free_idx[i+1]),
         .out_occ          (ch_occ[i+1]),
         .cmd              (cmd),
         .cmd_idx          (cmd_idx),
         .cmd_drop_rank    (cmd_drop_rank),
         .cmd_new_rank     (cmd_new_rank),
         .cmd_key          (key_ff),
         .cmd_value        (value_ff)
      );
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ch_flags[CAPACITY].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_ready = 1'b0;
      capture   = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   capture   = ch_flags[CAPACITY].valid;
         ST_FINISH: finish_go = out_free;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (capture) begin
         hold_flags_ff       <= ch_flags[CAPACITY];
         hold_found_idx_ff   <= ch_found_idx[CAPACITY];
         hold_found_rank_ff  <= ch_found_rank[CAPACITY];
         hold_found_value_ff <= ch_found_value[CAPACITY];
         hold_victim_idx_ff  <= ch_victim_idx[CAPACITY];
         hold_victim_rank_ff <= ch_victim_rank[CAPACITY];
         hold_victim_key_ff  <= ch_victim_key[CAPACITY];
         hold_free_idx_ff    <= ch_free_idx[CAPACITY];
         hold_occ_ff         <= ch_occ[CAPACITY];
      end
   end

   // capacities above CAPACITY act as CAPACITY
   assign cap_ext = CMP_W'(capacity);
   assign cap_lim = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
   assign occ_ext = CMP_W'(hold_occ_ff);
   assign full    = occ_ext >= cap_lim;
   assign no_room = cap_lim == '0;
   assign occ_dec = hold_occ_ff - OCC_W'(1);

   always_comb begin
      cmd_raw         = '0;
      cmd_idx         = hold_found_idx_ff;
      cmd_drop_rank   = hold_found_rank_ff;
      cmd_new_rank    = occ_dec[RANK_W-1:0];
      res_hit         = 1'b0;
      res_read_value  = '0;
      res_evicted     = 1'b0;
      res_evicted_key = '0;
      if (hold_flags_ff.found && (func_ff == FUNC_GET)) begin
         cmd_raw.en      = 1'b1;
         cmd_raw.drop_en = 1'b1;
         cmd_raw.inc     = 1'b1;
         res_hit         = 1'b1;
         res_read_value  = hold_found_value_ff;
      end else if ((func_ff == FUNC_PUT) && !no_room) begin
         if (hold_flags_ff.found) begin
            cmd_raw.en          = 1'b1;
            cmd_raw.drop_en     = 1'b1;
            cmd_raw.inc         = 1'b1;
            cmd_raw.write_value = 1'b1;
            res_hit             = 1'b1;
            res_read_value      = value_ff;
         end else if (full) begin
            // victim slot takes the new key as the most recent entry
            cmd_raw.en          = 1'b1;
            cmd_raw.drop_en     = 1'b1;
            cmd_raw.install     = 1'b1;
            cmd_raw.write_value = 1'b1;
            cmd_idx             = hold_victim_idx_ff;
            cmd_drop_rank       = hold_victim_rank_ff;
            res_evicted         = 1'b1;
            res_evicted_key     = hold_victim_key_ff;
         end else begin
            cmd_raw.en          = 1'b1;
            cmd_raw.install     = 1'b1;
            cmd_raw.write_value = 1'b1;
            cmd_idx             = hold_free_idx_ff;
            cmd_new_rank        = hold_occ_ff[RANK_W-1:0];
         end
      end
   end

   always_comb begin
      cmd    = cmd_raw;
      cmd.en = cmd_raw.en && finish_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_hit_ff         <= res_hit;
         rsp_read_value_ff  <= res_read_value;
         rsp_evicted_ff     <= res_evicted;
         rsp_evicted_key_ff <= res_evicted_key;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

[sv/lfuc_checker.sv]
`include "lfu_cache_lru_tiebreak_unit_defines.svh"

module lfuc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_value,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_key
);

   // one request in flight: busy right after a transfer
   `LFUC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // a pending response is not dropped
   `LFUC_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

   // a hit never evicts
   `LFUC_ASSERT_NOW(a_hit_no_evict, rsp_valid, !(rsp_hit && rsp_evicted))

   `LFUC_ASSERT_NOW(a_miss_zero_value, rsp_valid && !rsp_hit, rsp_read_value == 32'd0)

   `LFUC_ASSERT_NOW(a_no_evict_zero_key, rsp_valid && !rsp_evicted,
                    rsp_evicted_key == 32'd0)

endmodule

bind lfu_cache_lru_tiebreak_unit lfuc_checker u_lfuc_checker (.*);

[dv/lfu_rsp_checker.sv]
module lfu_rsp_checker
   import lfuc_pkg::*;
#(
   parameter int unsigned ENTRIES   = 16,
   parameter int unsigned USE_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_hit,
   input  logic [31:0] rsp_read_value,
   input  logic        rsp_evicted,
   input  logic [31:0] rsp_evicted_key,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);

   localparam int unsigned AGE_W = $clog2(ENTRIES);
   localparam logic [USE_WIDTH-1:0] USE_MAX = '1;
   // one response waiting plus one request in the row, with margin
   localparam int RSP_SLOTS = 4;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } cache_rsp_type;

   logic                 slot_valid [ENTRIES];
   logic [31:0]          slot_key   [ENTRIES];
   logic [31:0]          slot_value [ENTRIES];
   logic [USE_WIDTH-1:0] slot_uses  [ENTRIES];
   logic [AGE_W-1:0]     slot_age   [ENTRIES];
   logic [CAP_W-1:0]     capacity_reg;
   cache_rsp_type        rsp_model_fifo [RSP_SLOTS];
   int                   fifo_rd;
   int                   fifo_wr;
   int                   fifo_cnt;

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i])
            n++;
      return n;
   endfunction

   // take slot s out of the recency order; newer entries shift down
   function automatic void demote_newer(int s);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && i != s && slot_age[i] > slot_age[s])
            slot_age[i]--;
   endfunction

   function automatic cache_rsp_type cache_access(logic func, logic [31:0] key,
                                                  logic [31:0] value);
      cache_rsp_type r;
      int limit;
      int found;
      int slot;
      int n;
      r = '0;
      limit = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == key)
            found = i;
      if (found >= 0 && (func == FUNC_GET || limit != 0)) begin
         n = live_count();
         if (func == FUNC_PUT)
            slot_value[found] = value;
         if (slot_uses[found] != USE_MAX)
            slot_uses[found]++;
         demote_newer(found);
         slot_age[found] = AGE_W'(n - 1);
         r.hit = 1'b1;
         r.read_value = slot_value[found];
      end else if (func == FUNC_PUT && found < 0 && limit != 0) begin
         n = live_count();
         slot = -1;
         if (n >= limit) begin
            // lowest use count wins, oldest among equals
            for (int i = 0; i < ENTRIES; i++)
               if (slot_valid[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
                   (slot_uses[i] == slot_uses[slot] && slot_age[i] < slot_age[slot])))
                  slot = i;
            r.evicted = 1'b1;
            r.evicted_key = slot_key[slot];
            demote_newer(slot);
            slot_valid[slot] = 1'b0;
            n--;
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !slot_valid[i])
                  slot = i;
         end
         slot_valid[slot] = 1'b1;
         slot_key[slot] = key;
         slot_value[slot] = value;
         slot_uses[slot] = 1;
         slot_age[slot] = AGE_W'(n);
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      cache_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            slot_valid[i] = 1'b0;
         capacity_reg = CAP_RESET;
         fifo_rd = 0;
         fifo_wr = 0;
         fifo_cnt = 0;
         mismatches = 0;
      end else begin
         if (psel && penable && pready && paddr[2] == CSR_WORD_CAPACITY) begin
            if (pwrite)
               capacity_reg = pwdata[CAP_W-1:0];
            else
               check_field("prdata", 32'(capacity_reg), prdata);
         end
         if (rsp_valid && rsp_ready) begin
            if (fifo_cnt == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = rsp_model_fifo[fifo_rd];
               fifo_rd = (fifo_rd + 1) % RSP_SLOTS;
               fifo_cnt--;
               check_field("rsp_hit", 32'(want.hit), 32'(rsp_hit));
               check_field("rsp_read_value", want.read_value, rsp_read_value);
               check_field("rsp_evicted", 32'(want.evicted), 32'(rsp_evicted));
               check_field("rsp_evicted_key", want.evicted_key, rsp_evicted_key);
            end
         end
         if (req_valid && req_ready) begin
            if (fifo_cnt == RSP_SLOTS) begin
               $error("more requests outstanding than the design can hold");
               mismatches++;
            end else begin
               rsp_model_fifo[fifo_wr] = cache_access(req_func, req_key, req_value);
               fifo_wr = (fifo_wr + 1) % RSP_SLOTS;
               fifo_cnt++;
            end
         end
      end
      pending = fifo_cnt;
   end

endmodule

[dv/tb_top.sv]
module tb_top;
   import lfuc_pkg::*;

   localparam int unsigned CAPACITY    = 16;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned KEY_POOL    = 20;
   localparam int unsigned PHASES      = 8;
   // enough hits to lift one entry's use count far above any newcomer
   localparam int unsigned HOT_HITS    = 40;
   localparam logic [31:0] HOT_KEY     = 32'h5A5A_C3C3;
   localparam logic [2:0]  CAPACITY_ADDR = {CSR_WORD_CAPACITY, 2'b00};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_GET;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [31:0] rsp_read_value;
   logic        rsp_evicted;
   logic [31:0] rsp_evicted_key;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          mismatches;
   int          pending;
   bit          gaps_on = 1'b1;
   logic [31:0] key_pool [KEY_POOL];
   int          phase_cap [PHASES] = '{16, 4, 1, 31, 0, 9, 16, 2};
   int          phase_len [PHASES] = '{240, 220, 150, 280, 60, 220, 300, 220};

   lfu_cache_lru_tiebreak_unit #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   lfu_rsp_checker #(
      .ENTRIES   (CAPACITY),
      .USE_WIDTH (COUNT_WIDTH)
   ) rsp_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) rsp_ready <= !gaps_on || ($urandom_range(99) >= 15);

   // starts and ends on a falling edge; valid stays up between back-to-back transfers
   task automatic send_request(logic func, logic [31:0] key, logic [31:0] value);
      while (gaps_on && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_key <= key;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic random_request();
      logic        func;
      logic [31:0] key;
      logic [31:0] value;
      int          pick;
      func = ($urandom_range(1) == 1) ? FUNC_PUT : FUNC_GET;
      key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom();
      pick = $urandom_range(9);
      value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
      send_request(func, key, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // write capacity, then read it back
   task automatic set_capacity(logic [CAP_W-1:0] cap);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CAPACITY_ADDR;
      pwdata <= 32'(cap);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL; i++)
         key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h0000_0001;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty cache, insert, hit on get and put, miss
      send_request(FUNC_GET, 32'h0, 32'h0);
      send_request(FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
      send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0);
      send_request(FUNC_GET, 32'h0, 32'h0);
      send_request(FUNC_PUT, 32'h0, 32'h1234_5678);
      send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_GET, 32'h5, 32'h0);

      // storing disabled, lookups still see held entries
      drain();
      set_capacity(5'd0);
      send_request(FUNC_PUT, 32'h7, 32'h7);
      send_request(FUNC_GET, 32'h0, 32'h0);

      // capacity below occupancy: a put replaces, never grows
      drain();
      set_capacity(5'd1);
      send_request(FUNC_PUT, 32'h8, 32'h8);
      send_request(FUNC_GET, 32'h8, 32'h0);
      send_request(FUNC_PUT, 32'h9, 32'h9);

      // out-of-range setting acts as full size
      drain();
      set_capacity(5'd31);
      for (int i = 0; i < 4; i++)
         send_request(FUNC_PUT, 32'h30 + i, 32'hA000_0000 + i);
      send_request(FUNC_GET, 32'h30, 32'h0);

      // equal counts: oldest goes first
      drain();
      set_capacity(5'd3);
      send_request(FUNC_PUT, 32'h40, 32'h40);
      send_request(FUNC_PUT, 32'h41, 32'h41);

      // heavily used entry must never be the victim
      drain();
      set_capacity(5'd2);
      gaps_on = 1'b0;
      send_request(FUNC_PUT, HOT_KEY, 32'h0BAD_F00D);
      repeat (HOT_HITS)
         send_request(FUNC_GET, HOT_KEY, $urandom());
      for (int i = 0; i < 4; i++)
         send_request(FUNC_PUT, 32'h7000_0000 + i, $urandom());
      send_request(FUNC_GET, HOT_KEY, 32'h0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_capacity(CAP_W'(phase_cap[p]));
         gaps_on = (p != 3);
         repeat (phase_len[p])
            random_request();
      end

      drain();
      repeat (CAPACITY + 4) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
